[sv/lsdh_pkg.sv]
// ---------------------------------------------------------------------------
// LRU stack distance histogram package
// Shared field widths, action codes and the cell control group.
// ---------------------------------------------------------------------------
package lsdh_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned BIN_IDX_W = 4;
   localparam int unsigned DIST_W    = 6;
   localparam int unsigned COUNT_W   = 32;

   typedef enum logic [1:0] {
      ACT_RECORD   = 2'd0,
      ACT_READ_BIN = 2'd1,
      ACT_CLEAR    = 2'd2
   } action_type;

   typedef struct packed {
      logic match_en;   // register the compare result in every cell
      logic shift_en;   // advance entries towards the bottom up to the limit
   } cell_ctrl_type;

endpackage

[sv/lsdh_if.sv]
// ---------------------------------------------------------------------------
// LRU stack distance histogram channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface lsdh_req_if import lsdh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   action_type           action;
   logic [ADDR_W-1:0]    address;
   logic [BIN_IDX_W-1:0] bin_index;

   modport source (output valid, action, address, bin_index, input ready);
   modport sink   (input valid, action, address, bin_index, output ready);
endinterface

interface lsdh_rsp_if import lsdh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [DIST_W-1:0]  distance;
   logic [COUNT_W-1:0] bin_count;

   modport source (output valid, hit, distance, bin_count, input ready);
   modport sink   (input valid, hit, distance, bin_count, output ready);
endinterface

[sv/lsdh_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lsdh_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lsdh_cell.sv]
// ---------------------------------------------------------------------------
// LRU stack cell
// Holds one stack entry, compares it with the key and takes its
// neighbour's entry when the stack advances past this depth.
// ---------------------------------------------------------------------------
module lsdh_cell import lsdh_pkg::*; #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned POS_W = 6,
   parameter int unsigned OCC_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0] key,
   input  logic [POS_W-1:0]  limit,
   input  logic [OCC_W-1:0]  occupancy,
   input  logic [ADDR_W-1:0] shift_in,
   output logic [ADDR_W-1:0] entry,
   output logic              match
);

   logic [ADDR_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;
   logic              valid;

   // Entry is live only while it sits above the fill level
   assign valid = 32'(occupancy) > INDEX;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_en && (32'(limit) >= INDEX)) begin
         entry_in = shift_in;
      end
      match_in = match_ff;
      if (ctrl.match_en) begin
         match_in = valid && (entry_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

[sv/lru_stack_distance_histogram.sv]
// A record access runs MATCH, ENCODE, BUMP and WRITE, a bin read LOOKUP and READ, and a clear
// or unknown action goes straight to DONE, where the response is registered once the output
// register is free. One transaction in flight: a new request is taken only in IDLE.
// A finished response waits in the output register while the next transaction is accepted.
// Reset (synchronous, active high) empties the stack and zeroes every histogram bin at once
// through per-bin valid bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
// LRU stack distance histogram
// Row of compare-and-shift cells forming a bounded LRU stack, with a
// saturating histogram of stack distances kept in a small RAM.
// ---------------------------------------------------------------------------
module lru_stack_distance_histogram import lsdh_pkg::*; #(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned BIN_COUNT   = 16
) (
   input  logic       clock,
   input  logic       reset,
   lsdh_req_if.sink   req,
   lsdh_rsp_if.source rsp
);

   localparam int unsigned POS_W = $clog2(STACK_DEPTH);
   localparam int unsigned OCC_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned BIN_W = $clog2(BIN_COUNT);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MATCH  = 8'b0000_0010,
      S_ENCODE = 8'b0000_0100,
      S_BUMP   = 8'b0000_1000,
      S_WRITE  = 8'b0001_0000,
      S_LOOKUP = 8'b0010_0000,
      S_READ   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Accepted transaction
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic               range_ok_ff, range_ok_in;

   // Stack bookkeeping
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               hit_ff, hit_in;

   // Result waiting for the output register
   logic               res_hit_ff, res_hit_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Histogram bins: valid bit set on first write, clear bin reads as zero
   logic               bin_valid_ff [BIN_COUNT];
   logic               ram_wr_en;
   logic [BIN_W-1:0]   ram_rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;
   logic [COUNT_W-1:0] ram_wr_data;
   logic [COUNT_W-1:0] cur_count;
   logic [BIN_W-1:0]   bump_bin;

   // Cell row
   cell_ctrl_type      cell_ctrl;
   logic [POS_W-1:0]   shift_limit;
   logic [ADDR_W-1:0]  entries [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] match_vec;
   logic [POS_W-1:0]   pos_enc;

   logic               req_fire;
   logic               out_free;
   logic [DIST_W+POS_W-1:0] dist_wide;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // -------------------------------------------------------------------
   // Cell row: cell 0 takes the new address, every other cell its
   // upper neighbour's entry, down to the shift limit.
   // -------------------------------------------------------------------
   assign cell_ctrl.match_en = (state_ff == S_MATCH);
   assign cell_ctrl.shift_en = (state_ff == S_BUMP);

   // Hit: close the gap at the found depth. Miss: push, dropping the
   // bottom entry when the stack is full.
   always_comb begin
      if (hit_ff) begin
         shift_limit = pos_ff;
      end else if (occ_ff >= OCC_W'(STACK_DEPTH)) begin
         shift_limit = POS_W'(STACK_DEPTH - 1);
      end else begin
         shift_limit = POS_W'(occ_ff);
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [ADDR_W-1:0] shift_in;
      if (i == 0) begin : g_top
         assign shift_in = addr_ff;
      end else begin : g_rest
         assign shift_in = entries[i-1];
      end
      lsdh_cell #(
         .INDEX (i),
         .POS_W (POS_W),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .key       (addr_ff),
         .limit     (shift_limit),
         .occupancy (occ_ff),
         .shift_in  (shift_in),
         .entry     (entries[i]),
         .match     (match_vec[i])
      );
   end

   // Live entries are distinct, so at most one cell matches: OR its index out
   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (match_vec[i]) begin
            pos_enc = pos_enc | POS_W'(i);
         end
      end
   end

   // Deep hits and misses land in the last bin
   always_comb begin
      if (!hit_ff || (32'(pos_ff) >= (BIN_COUNT - 1))) begin
         bump_bin = BIN_W'(BIN_COUNT - 1);
      end else begin
         bump_bin = BIN_W'(pos_ff);
      end
   end

   // -------------------------------------------------------------------
   // Histogram RAM: read in BUMP or LOOKUP, write back in WRITE
   // -------------------------------------------------------------------
   assign ram_rd_addr = (state_ff == S_BUMP) ? bump_bin : bin_ff;
   assign cur_count   = bin_valid_ff[bin_ff] ? ram_rd_data : '0;
   assign ram_wr_data = (&cur_count) ? cur_count : cur_count + COUNT_W'(1);
   assign ram_wr_en   = (state_ff == S_WRITE);

   lsdh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (BIN_COUNT)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bin_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Fit the depth into the distance field, truncating when deeper
   assign dist_wide = {{DIST_W{1'b0}}, res_pos_ff};

   // -------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      bin_in       = bin_ff;
      range_ok_in  = range_ok_ff;
      occ_in       = occ_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      res_hit_in   = res_hit_ff;
      res_pos_in   = res_pos_ff;
      res_count_in = res_count_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_count_in = rsp_count_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               addr_in      = req.address;
               bin_in       = BIN_W'(req.bin_index);
               range_ok_in  = 32'(req.bin_index) < BIN_COUNT;
               res_hit_in   = 1'b0;
               res_pos_in   = '0;
               res_count_in = '0;
               case (req.action)
                  ACT_RECORD:   state_in = S_MATCH;
                  ACT_READ_BIN: state_in = S_LOOKUP;
                  ACT_CLEAR: begin
                     occ_in   = '0;
                     state_in = S_DONE;
                  end
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_MATCH: begin
            state_in = S_ENCODE;
         end
         S_ENCODE: begin
            hit_in   = |match_vec;
            pos_in   = pos_enc;
            state_in = S_BUMP;
         end
         S_BUMP: begin
            // Cells advance this cycle; the bin read goes out at the same time
            bin_in = bump_bin;
            if (!hit_ff && (occ_ff < OCC_W'(STACK_DEPTH))) begin
               occ_in = occ_ff + OCC_W'(1);
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            res_hit_in = hit_ff;
            res_pos_in = hit_ff ? pos_ff : '0;
            state_in   = S_DONE;
         end
         S_LOOKUP: begin
            state_in = S_READ;
         end
         S_READ: begin
            res_count_in = range_ok_ff ? cur_count : '0;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // Hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_dist_in  = dist_wide[DIST_W-1:0];
               rsp_count_in = res_count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_in_ff_block: begin
         addr_ff      <= addr_in;
         bin_ff       <= bin_in;
         range_ok_ff  <= range_ok_in;
         pos_ff       <= pos_in;
         hit_ff       <= hit_in;
         res_hit_ff   <= res_hit_in;
         res_pos_ff   <= res_pos_in;
         res_count_ff <= res_count_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_dist_ff  <= rsp_dist_in;
         rsp_count_ff <= rsp_count_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Bin valid bits: drop all on reset, mark a bin once written
   always_ff @(posedge clock) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
         if (reset) begin
            bin_valid_ff[i] <= 1'b0;
         end else if (ram_wr_en && (32'(bin_ff) == i)) begin
            bin_valid_ff[i] <= 1'b1;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.distance  = rsp_dist_ff;
   assign rsp.bin_count = rsp_count_ff;

   // -------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= STACK_DEPTH)
      else $error("occupancy beyond stack depth");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ENCODE |-> $onehot0(match_vec))
      else $error("address held in more than one live cell");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUMP) && hit_ff |-> 32'(pos_ff) < 32'(occ_ff))
      else $error("hit depth outside the live stack");

   a_bin_marked: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |=> bin_valid_ff[$past(bin_ff)])
      else $error("written bin not marked valid");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req.action == ACT_CLEAR) |=> occ_ff == '0)
      else $error("stack not emptied after clear");

endmodule
